>>> rtl/timed_reply_delay_queue_defines.svh
// ----------------------------------------------------------------------------
// Timed reply delay queue: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TIMED_REPLY_DELAY_QUEUE_DEFINES_SVH
`define TIMED_REPLY_DELAY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TRDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trdq assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TRDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trdq assertion failed");

`endif

>>> rtl/trdq_pkg.sv
// ----------------------------------------------------------------------------
// trdq_pkg
// Types and constants of the timed reply delay queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trdq_pkg;

  // Field widths
  localparam int unsigned IdW      = 48;
  localparam int unsigned NumW     = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned BaseW    = 16;
  localparam int unsigned DelayW   = BaseW + 1;
  localparam int unsigned StepW    = 17;
  localparam int unsigned CountW   = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Query counter wraps after this value
  localparam logic [CountW-1:0] CountWrap = CountW'(999999);

  // Results released by one tick at most
  localparam int unsigned MaxResults = 16;
  localparam int unsigned RelCntW    = $clog2(MaxResults);

  // Reply opcodes
  localparam logic [1:0] OPC_HIT  = 2'd2;
  localparam logic [1:0] OPC_MISS = 2'd3;

  // Item kinds
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    MGMT_NONE        = 2'd0,
    MGMT_ENABLE_HIT  = 2'd1,
    MGMT_DISABLE_HIT = 2'd2,
    MGMT_RESERVED    = 2'd3   // ignored
  } mgmt_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_DELAY  = 3'd0,
    CFG_DITHER_STEP = 3'd1,
    CFG_EVERY_NTH   = 3'd2,
    CFG_ALWAYS_MISS = 3'd3,
    CFG_REMOTE_MGMT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_TICK
  } state_e;

  // One queued reply
  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   requester;
    logic [NumW-1:0]  number;
    logic             miss;
  } entry_t;

  // Broadcast to every cell
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [TimeW-1:0]  now_ms;
    logic [DelayW-1:0] delay;
  } cell_ctl_t;

  // Head status reported by the chain
  typedef struct packed {
    logic head_valid;
    logic head_due;
    logic next_due;
    logic full;
  } chain_stat_t;

endpackage

`default_nettype wire

>>> rtl/trdq_if.sv
// ----------------------------------------------------------------------------
// trdq interfaces
// Valid/ready channels for query/tick items, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Input items: queries and millisecond ticks
interface trdq_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [47:0] requester_id;
  logic [31:0] request_number;
  logic [1:0]  mgmt_command;

  modport source (output valid, op, requester_id, request_number, mgmt_command,
                  input ready);
  modport sink   (input valid, op, requester_id, request_number, mgmt_command,
                  output ready);
endinterface

// Result items: replies and drop notices
interface trdq_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] requester_id_out;
  logic [31:0] request_number_out;
  logic [1:0]  reply_opcode;
  logic        status;
  logic        last;

  modport source (output valid, requester_id_out, request_number_out, reply_opcode,
                  status, last, input ready);
  modport sink   (input valid, requester_id_out, request_number_out, reply_opcode,
                  status, last, output ready);
endinterface

// Register writes
interface trdq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/trdq_cell.sv
// ----------------------------------------------------------------------------
// trdq_cell
// One slot of the deadline-sorted chain: keeps, shifts in from a neighbor,
// or takes the new entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdq_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  trdq_pkg::cell_ctl_t   ctl_i,
  input  trdq_pkg::entry_t      new_entry_i,
  input  wire                   prev_valid_i,
  input  trdq_pkg::entry_t      prev_entry_i,
  input  wire                   prev_before_i,
  input  wire                   next_valid_i,
  input  trdq_pkg::entry_t      next_entry_i,
  output logic                  valid_o,
  output trdq_pkg::entry_t      entry_o,
  output logic                  before_o
);
  import trdq_pkg::*;

  logic             valid_q, valid_d;
  entry_t           entry_q, entry_d;
  logic [TimeW-1:0] diff;

  // Entry stays ahead of the new one when its offset is not later (FIFO on ties)
  assign diff     = entry_q.deadline - ctl_i.now_ms;
  assign before_o = valid_q &&
                    ($signed(diff) <= $signed({{(TimeW-DelayW){1'b0}}, ctl_i.delay}));

  // Next slot contents
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (!before_o) begin
        if (prev_before_i) begin
          valid_d = 1'b1;
          entry_d = new_entry_i;
        end else begin
          valid_d = prev_valid_i;
          entry_d = prev_entry_i;
        end
      end
    end else if (ctl_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> rtl/trdq_chain.sv
// ----------------------------------------------------------------------------
// trdq_chain
// Row of cells holding the queued replies in deadline order, head at cell 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trdq_chain #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  trdq_pkg::cell_ctl_t     ctl_i,
  input  trdq_pkg::entry_t        new_entry_i,
  output trdq_pkg::entry_t        head_entry_o,
  output trdq_pkg::chain_stat_t   stat_o
);
  import trdq_pkg::*;

  logic             valid  [QUEUE_DEPTH];
  entry_t           entry  [QUEUE_DEPTH];
  logic             ahead  [QUEUE_DEPTH];
  logic [TimeW-1:0] head_diff, next_diff;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_valid, prev_before, next_valid;
    entry_t prev_entry, next_entry;

    if (i == 0) begin : g_first
      assign prev_valid  = 1'b0;
      assign prev_entry  = entry_t'('0);
      assign prev_before = 1'b1;
    end else begin : g_mid
      assign prev_valid  = valid[i-1];
      assign prev_entry  = entry[i-1];
      assign prev_before = ahead[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = entry_t'('0);
    end else begin : g_inner
      assign next_valid = valid[i+1];
      assign next_entry = entry[i+1];
    end

    trdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl_i),
      .new_entry_i   (new_entry_i),
      .prev_valid_i  (prev_valid),
      .prev_entry_i  (prev_entry),
      .prev_before_i (prev_before),
      .next_valid_i  (next_valid),
      .next_entry_i  (next_entry),
      .valid_o       (valid[i]),
      .entry_o       (entry[i]),
      .before_o      (ahead[i])
    );
  end

  // Due: deadline at or before now, as a signed offset
  assign head_diff = entry[0].deadline - ctl_i.now_ms;
  assign next_diff = entry[1].deadline - ctl_i.now_ms;

  assign head_entry_o      = entry[0];
  assign stat_o.head_valid = valid[0];
  assign stat_o.head_due   = valid[0] && !($signed(head_diff) > $signed(32'sd0));
  assign stat_o.next_due   = valid[1] && !($signed(next_diff) > $signed(32'sd0));
  assign stat_o.full       = valid[QUEUE_DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/timed_reply_delay_queue.sv
// ----------------------------------------------------------------------------
// timed_reply_delay_queue
// Answers queries with HIT/MISS replies, at once or after a delay in ms.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries queries (op 0) and one-millisecond ticks (op 1). result_o
//   carries replies; last marks the final result of an item. cfg_i writes the
//   five registers by index and is always ready; write only while idle.
//   A query is accepted in ST_IDLE; in ST_QUERY it updates the counters and
//   either inserts into the sorted chain or places an immediate/drop result.
//   Insertion is a single parallel step: every cell compares its deadline
//   with the new one and keeps, shifts right or takes the new entry.
//   A tick is accepted in ST_IDLE; in ST_TICK the head cell is checked and,
//   while the output register is free, popped once a cycle, the chain
//   shifting left, until no head is due or 16 replies are released.
//   A one-entry output register sits before result_o; while it is stalled
//   a step that must load it holds and item_i.ready stays low.
//   Reset empties the chain, zeroes time and counters, selects HIT and loads
//   register defaults (delay 5 ms, every query answered).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timed_reply_delay_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  trdq_item_if.sink             item_i,
  trdq_result_if.source         result_o,
  trdq_cfg_if.sink              cfg_i
);
  import trdq_pkg::*;

  // Registers
  logic [BaseW-1:0]  base_q;
  logic [StepW-1:0]  step_q;
  logic [CountW-1:0] nth_q;
  logic              always_miss_q, remote_q;

  // Block state
  state_e            state_q, state_d;
  logic [TimeW-1:0]  now_q;
  logic [CountW-1:0] qcount_q;
  logic [CountW-1:0] residue_q;
  logic [TimeW-1:0]  stepsum_q;
  logic              miss_q;
  logic [RelCntW-1:0] relcnt_q;

  // Latched query
  logic [IdW-1:0]    id_q;
  logic [NumW-1:0]   num_q;
  logic [1:0]        cmd_q;

  // Output register
  logic              out_valid_q;
  logic [IdW-1:0]    out_id_q;
  logic [NumW-1:0]   out_num_q;
  logic [1:0]        out_opc_q;
  logic              out_status_q, out_last_q;

  logic              out_free, accept, load_out, commit_query;
  logic              out_miss, out_status, out_last, release_one;
  logic [IdW-1:0]    out_id;
  logic [NumW-1:0]   out_num;
  logic              miss_new, dither_hit, extra, answer, need_out, zero_delay;
  logic [DelayW-1:0] delay;
  logic [CountW:0]   residue_inc;
  cell_ctl_t         ctl;
  entry_t            new_entry, head_entry;
  chain_stat_t       stat;

  assign out_free     = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Query decisions
  always_comb begin
    miss_new = miss_q;
    if (remote_q) begin
      case (cmd_q)
        MGMT_ENABLE_HIT:  miss_new = 1'b0;
        MGMT_DISABLE_HIT: miss_new = 1'b1;
        default:          miss_new = miss_q;
      endcase
    end
  end

  assign dither_hit  = ({{(TimeW-CountW){1'b0}}, qcount_q} == stepsum_q) ||
                       (qcount_q == CountWrap);
  assign extra       = !always_miss_q && dither_hit;
  assign delay       = {1'b0, base_q} + {{(DelayW-1){1'b0}}, extra};
  assign zero_delay  = (delay == '0);
  assign answer      = !always_miss_q && (residue_q == '0);
  assign need_out    = always_miss_q || (answer && (zero_delay || stat.full));
  assign residue_inc = {1'b0, residue_q} + 1'b1;

  // Sequencer: next state, chain control, output load
  always_comb begin
    state_d      = state_q;
    commit_query = 1'b0;
    release_one  = 1'b0;
    load_out     = 1'b0;
    out_id       = id_q;
    out_num      = num_q;
    out_miss     = always_miss_q || miss_new;
    out_status   = 1'b0;
    out_last     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (item_i.op == OP_TICK) ? ST_TICK : ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (!need_out || out_free) begin
          commit_query = 1'b1;
          load_out     = need_out;
          out_status   = answer && !zero_delay && stat.full;
          state_d      = ST_IDLE;
        end
      end
      ST_TICK: begin
        out_id   = head_entry.requester;
        out_num  = head_entry.number;
        out_miss = head_entry.miss;
        out_last = !stat.next_due || (relcnt_q == RelCntW'(MaxResults - 1));
        if (!stat.head_due) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          release_one = 1'b1;
          load_out    = 1'b1;
          if (out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ctl.insert = commit_query && answer && !zero_delay && !stat.full;
  assign ctl.pop    = release_one;
  assign ctl.now_ms = now_q;
  assign ctl.delay  = delay;

  assign new_entry.deadline  = now_q + {{(TimeW-DelayW){1'b0}}, delay};
  assign new_entry.requester = id_q;
  assign new_entry.number    = num_q;
  assign new_entry.miss      = miss_new;

  trdq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .new_entry_i  (new_entry),
    .head_entry_o (head_entry),
    .stat_o       (stat)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= BaseW'(5);
      step_q        <= '0;
      nth_q         <= CountW'(1);
      always_miss_q <= 1'b0;
      remote_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BASE_DELAY:  base_q        <= cfg_i.data[BaseW-1:0];
        CFG_DITHER_STEP: step_q        <= cfg_i.data[StepW-1:0];
        CFG_EVERY_NTH:   nth_q         <= cfg_i.data[CountW-1:0];
        CFG_ALWAYS_MISS: always_miss_q <= cfg_i.data[0];
        CFG_REMOTE_MGMT: remote_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Time, counters, reply kind, release count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      qcount_q  <= '0;
      residue_q <= '0;
      stepsum_q <= '0;
      miss_q    <= 1'b0;
      relcnt_q  <= '0;
    end else begin
      if (accept && item_i.op == OP_TICK) begin
        now_q    <= now_q + 1'b1;
        relcnt_q <= '0;
      end
      if (release_one) begin
        relcnt_q <= relcnt_q + 1'b1;
      end
      if (commit_query) begin
        miss_q <= miss_new;
        if (qcount_q >= CountWrap) begin
          qcount_q  <= '0;
          residue_q <= '0;
          stepsum_q <= '0;
        end else begin
          qcount_q  <= qcount_q + 1'b1;
          residue_q <= (residue_inc >= {1'b0, nth_q}) ? '0 : residue_inc[CountW-1:0];
          if (extra) begin
            stepsum_q <= stepsum_q + {{(TimeW-StepW){1'b0}}, step_q};
          end
        end
      end
    end
  end

  // Latch the query payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q  <= item_i.requester_id;
      num_q <= item_i.request_number;
      cmd_q <= item_i.mgmt_command;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_id_q     <= out_id;
      out_num_q    <= out_num;
      out_opc_q    <= out_miss ? OPC_MISS : OPC_HIT;
      out_status_q <= out_status;
      out_last_q   <= out_last;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.requester_id_out   = out_id_q;
  assign result_o.request_number_out = out_num_q;
  assign result_o.reply_opcode       = out_opc_q;
  assign result_o.status             = out_status_q;
  assign result_o.last               = out_last_q;

endmodule

`default_nettype wire

>>> rtl/trdq_checker.sv
// ----------------------------------------------------------------------------
// trdq_checker
// Port-level checks of the timed reply delay queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "timed_reply_delay_queue_defines.svh"

module trdq_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [1:0]  out_opcode_i,
  input wire        out_status_i,
  input wire        out_last_i
);
  import trdq_pkg::*;

  logic out_stall;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result stays offered
  `TRDQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i)

  // Only HIT or MISS goes out
  `TRDQ_ASSERT_NOW(a_opcode, out_valid_i, (out_opcode_i == OPC_HIT) || (out_opcode_i == OPC_MISS))

  // A drop notice is the only result of its query
  `TRDQ_ASSERT_NOW(a_drop_last, out_valid_i && out_status_i, out_last_i)

  // One item at a time: no acceptance right after an acceptance
  `TRDQ_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind timed_reply_delay_queue trdq_checker u_trdq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_opcode_i (result_o.reply_opcode),
  .out_status_i (result_o.status),
  .out_last_i   (result_o.last)
);

`default_nettype wire

>>> verif/timed_reply_delay_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_reply_delay_queue_tb
// Drives queries and millisecond ticks into the delay queue under random
// stalls on both sides. Every accepted item is run through a cycle-free
// prediction of counters, reply kind and the deadline-sorted schedule. Each
// reply is checked, in order, against the predicted one.
// ----------------------------------------------------------------------------

module timed_reply_delay_queue_tb;
  import trdq_pkg::*;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned DrainCycles = 48;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned MaxGap      = 24;
  localparam logic [TimeW-1:0] DueBound = 32'h8000_0000;

  // One predicted or observed reply
  typedef struct packed {
    logic [IdW-1:0]  requester;
    logic [NumW-1:0] number;
    logic [1:0]      opcode;
    logic            status;
    logic            last;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  trdq_item_if   item_if ();
  trdq_result_if res_if ();
  trdq_cfg_if    cfg_if ();

  timed_reply_delay_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // Mirrored registers
  logic [BaseW-1:0]  base_delay_q;
  logic [StepW-1:0]  dither_step_q;
  logic [CountW-1:0] every_nth_q;
  logic              always_miss_q;
  logic              remote_mgmt_q;

  // Predicted block state
  logic [TimeW-1:0]  now_ms_q;
  logic [CountW-1:0] query_cnt_q;
  logic [CountW-1:0] nth_res_q;
  logic [31:0]       step_sum_q;
  logic              reply_miss_q;
  entry_t            sched_q[$];
  reply_t            awaited_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned error_cnt;
  int unsigned stall_cnt;
  reply_t      seen_reply;
  reply_t      want_reply;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req != 0) begin
      hold_left    <= hold_req - 1;
      hold_req      = 0;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Reply checker: oldest prediction first
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_reply = {res_if.requester_id_out, res_if.request_number_out,
                    res_if.reply_opcode, res_if.status, res_if.last};
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected reply id=%h num=%h opc=%0d status=%0b last=%0b",
                 $time, seen_reply.requester, seen_reply.number, seen_reply.opcode,
                 seen_reply.status, seen_reply.last);
        error_cnt++;
      end else begin
        want_reply = awaited_q.pop_front();
        if (seen_reply !== want_reply) begin
          $display("%0t: reply mismatch id/num/opc/status/last", $time,
                   " expected %h/%h/%0d/%0b/%0b", want_reply.requester,
                   want_reply.number, want_reply.opcode, want_reply.status,
                   want_reply.last,
                   " actual %h/%h/%0d/%0b/%0b", seen_reply.requester,
                   seen_reply.number, seen_reply.opcode, seen_reply.status,
                   seen_reply.last);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Signed offset of a deadline from now, biased so that larger is later
  function automatic logic [TimeW-1:0] order_key(input logic [TimeW-1:0] dl);
    return (dl - now_ms_q) ^ DueBound;
  endfunction

  function automatic logic is_due(input logic [TimeW-1:0] dl);
    return order_key(dl) <= DueBound;
  endfunction

  // Query: management, dither, nth selection, then reply or schedule
  function automatic void predict_query(input logic [IdW-1:0] id,
                                        input logic [NumW-1:0] num,
                                        input logic [1:0] cmd);
    logic              extra;
    logic [DelayW-1:0] delay;
    logic [TimeW-1:0]  dl;
    int unsigned       pos;
    entry_t            ent;
    reply_t            rep;
    if (remote_mgmt_q) begin
      if (cmd == MGMT_ENABLE_HIT) reply_miss_q = 1'b0;
      else if (cmd == MGMT_DISABLE_HIT) reply_miss_q = 1'b1;
    end
    rep.requester = id;
    rep.number    = num;
    rep.opcode    = reply_miss_q ? OPC_MISS : OPC_HIT;
    rep.status    = 1'b0;
    rep.last      = 1'b1;
    if (always_miss_q) begin
      rep.opcode = OPC_MISS;
      awaited_q.push_back(rep);
    end else begin
      extra = 1'b0;
      if (32'(query_cnt_q) == step_sum_q || query_cnt_q == CountWrap) begin
        extra      = 1'b1;
        step_sum_q = step_sum_q + 32'(dither_step_q);
      end
      if (nth_res_q == '0) begin
        delay = DelayW'(base_delay_q) + DelayW'(extra);
        if (delay == '0) begin
          awaited_q.push_back(rep);
        end else if (sched_q.size() >= QueueDepth) begin
          rep.status = 1'b1;
          awaited_q.push_back(rep);
        end else begin
          dl  = now_ms_q + TimeW'(delay);
          pos = sched_q.size();
          while (pos > 0 && order_key(sched_q[pos-1].deadline) > order_key(dl)) pos--;
          ent.deadline  = dl;
          ent.requester = id;
          ent.number    = num;
          ent.miss      = reply_miss_q;
          sched_q.insert(pos, ent);
        end
      end
    end
    if (query_cnt_q >= CountWrap) begin
      query_cnt_q = '0;
      step_sum_q  = '0;
      nth_res_q   = '0;
    end else begin
      query_cnt_q = query_cnt_q + 1'b1;
      nth_res_q   = (32'(nth_res_q) + 32'd1 >= 32'(every_nth_q)) ? '0 : nth_res_q + 1'b1;
    end
  endfunction

  // Tick: advance time and release due heads, at most MaxResults
  function automatic void predict_tick();
    int unsigned n;
    entry_t      ent;
    reply_t      rep;
    now_ms_q = now_ms_q + 1'b1;
    n = 0;
    while (sched_q.size() > 0 && n < MaxResults && is_due(sched_q[0].deadline)) begin
      ent = sched_q.pop_front();
      n++;
      rep.requester = ent.requester;
      rep.number    = ent.number;
      rep.opcode    = ent.miss ? OPC_MISS : OPC_HIT;
      rep.status    = 1'b0;
      rep.last      = (n == MaxResults) || (sched_q.size() == 0) ||
                      !is_due(sched_q[0].deadline);
      awaited_q.push_back(rep);
    end
  endfunction

  // Offer one item after a random gap; predict on acceptance.
  // valid is left high so a back-to-back item needs no second assignment.
  task automatic send_item(input logic op, input logic [IdW-1:0] id,
                           input logic [NumW-1:0] num, input logic [1:0] cmd);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid          <= 1'b1;
    item_if.op             <= op;
    item_if.requester_id   <= id;
    item_if.request_number <= num;
    item_if.mgmt_command   <= cmd;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (op == OP_TICK) predict_tick();
    else predict_query(id, num, cmd);
  endtask

  function automatic logic [IdW-1:0] pick_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {16'($urandom), $urandom};
    endcase
  endfunction

  function automatic logic [NumW-1:0] pick_num();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_query(input logic [1:0] cmd);
    send_item(OP_QUERY, pick_id(), pick_num(), cmd);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, pick_id(), pick_num(), 2'($urandom_range(3)));
  endtask

  // Stop offering and wait for every predicted reply
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_BASE_DELAY:  base_delay_q  = val[BaseW-1:0];
      CFG_DITHER_STEP: dither_step_q = val[StepW-1:0];
      CFG_EVERY_NTH:   every_nth_q   = val[CountW-1:0];
      CFG_ALWAYS_MISS: always_miss_q = val[0];
      CFG_REMOTE_MGMT: remote_mgmt_q = val[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle
  task automatic set_config(input logic [BaseW-1:0] base, input logic [StepW-1:0] step,
                            input logic [CountW-1:0] nth, input logic miss,
                            input logic mgmt);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(CFG_BASE_DELAY, CfgDataW'(base));
    write_reg(CFG_DITHER_STEP, CfgDataW'(step));
    write_reg(CFG_EVERY_NTH, CfgDataW'(nth));
    write_reg(CFG_ALWAYS_MISS, CfgDataW'(miss));
    write_reg(CFG_REMOTE_MGMT, CfgDataW'(mgmt));
  endtask

  // Reset defaults (5 ms, every query, HIT). The dither step goes in before
  // the first query, since the dither only keeps pace from query zero.
  task automatic test_defaults_and_dither();
    write_reg(CFG_DITHER_STEP, CfgDataW'(2));
    send_item(OP_QUERY, '0, '0, MGMT_NONE);
    send_item(OP_QUERY, '1, '1, MGMT_DISABLE_HIT);
    send_query(MGMT_NONE);
    repeat (7) send_tick();
  endtask

  // Management commands, unknown command, and remote control off
  task automatic test_mgmt_commands();
    set_config(0, 1, 1, 1'b0, 1'b1);
    send_query(MGMT_DISABLE_HIT);
    send_query(MGMT_RESERVED);
    send_query(MGMT_NONE);
    send_query(MGMT_ENABLE_HIT);
    set_config(0, 1, 1, 1'b0, 1'b0);
    send_query(MGMT_DISABLE_HIT);
    send_tick();
    send_tick();
  endtask

  // Only every third query gets a reply
  task automatic test_every_nth();
    set_config(1, 3, 3, 1'b0, 1'b1);
    repeat (5) send_query(2'($urandom_range(3)));
    repeat (3) send_tick();
  endtask

  // Receiver holds off while queries with base delay zero keep coming
  task automatic test_output_backpressure();
    set_config(0, 1, 1, 1'b0, 1'b0);
    hold_req = 200;
    repeat (14) send_query(MGMT_NONE);
    repeat (2) send_tick();
    wait_drained();
  endtask

  // Fill the schedule past its depth, then release a full batch on one tick
  task automatic test_queue_full();
    set_config(2, 1, 1, 1'b0, 1'b0);
    repeat (QueueDepth + 2) send_query(MGMT_NONE);
    hold_req = 120;
    repeat (4) send_tick();
    wait_drained();
  endtask

  // Random traffic; a new register setting every 20 items
  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                  input int unsigned n_items);
    logic [CountW-1:0] nth;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        nth = ($urandom_range(3) == 0) ? CountW'($urandom_range(2, 5)) : CountW'(1);
        set_config(BaseW'($urandom_range(0, 6)), StepW'($urandom_range(1, 5)), nth,
                   1'b0, 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 38) send_tick();
      else send_query(2'($urandom_range(3)));
    end
  endtask

  // Register extremes last: they stop the dither from keeping pace
  task automatic test_register_extremes();
    set_config(0, 0, 1, 1'b1, 1'b1);
    send_query(MGMT_ENABLE_HIT);
    send_query(MGMT_DISABLE_HIT);
    set_config(16'hFFFF, 17'd100000, 1, 1'b0, 1'b0);
    send_query(MGMT_NONE);
    send_query(MGMT_NONE);
    send_tick();
    set_config(0, 17'd100000, CountW'(999999), 1'b0, 1'b1);
    repeat (3) send_query(MGMT_ENABLE_HIT);
    // far deadlines must stay behind near ones
    set_config(3, 0, 1, 1'b0, 1'b0);
    repeat (2) send_query(MGMT_NONE);
    repeat (4) send_tick();
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    item_if.valid          <= 1'b0;
    item_if.op             <= OP_QUERY;
    item_if.requester_id   <= '0;
    item_if.request_number <= '0;
    item_if.mgmt_command   <= MGMT_NONE;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= CFG_BASE_DELAY;
    cfg_if.data            <= '0;
    base_delay_q  = 16'd5;
    dither_step_q = '0;
    every_nth_q   = 20'd1;
    always_miss_q = 1'b0;
    remote_mgmt_q = 1'b0;
    now_ms_q      = '0;
    query_cnt_q   = '0;
    nth_res_q     = '0;
    step_sum_q    = '0;
    reply_miss_q  = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 63;
    error_cnt     = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults_and_dither();
    test_mgmt_commands();
    test_every_nth();
    test_output_backpressure();
    test_queue_full();
    run_random_phase(35, 63, 90);
    run_random_phase(63, 35, 90);
    run_random_phase(0, 0, 90);
    test_register_extremes();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_cnt == 0 && awaited_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
